// ===== design/fpr_pkg.sv =====
// Shared types for the FIFO page replacement block: controller states and command bundle.
package fpr_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic update;
  } cmd_t;

  localparam int unsigned PORT_ADDR_BITS  = 48;
  localparam int unsigned PORT_FRAME_BITS = 6;

endpackage

// ===== design/fpr_ctrl.sv =====
// Controller state machine sequencing capture, compare and update for each access.
module fpr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output fpr_pkg::cmd_t cmd
);

  fpr_pkg::state_t state;
  fpr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fpr_pkg::ST_IDLE: begin
        if (start) begin
          state_next = fpr_pkg::ST_COMPARE;
        end
      end
      fpr_pkg::ST_COMPARE: begin
        state_next = fpr_pkg::ST_UPDATE;
      end
      fpr_pkg::ST_UPDATE: begin
        if (start) begin
          state_next = fpr_pkg::ST_COMPARE;
        end else begin
          state_next = fpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = (state == fpr_pkg::ST_COMPARE);
    cmd.capture = start && (state != fpr_pkg::ST_COMPARE);
    cmd.compare = (state == fpr_pkg::ST_COMPARE);
    cmd.update  = (state == fpr_pkg::ST_UPDATE);
  end

endmodule

// ===== design/fpr_datapath.sv =====
// Datapath: frame table, match vector, head/tail pointers and registered result.
module fpr_datapath #(
  parameter int unsigned FRAME_COUNT  = 8,
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fpr_pkg::cmd_t                        cmd,
  input  logic [fpr_pkg::PORT_ADDR_BITS-1:0]   page_address,
  output logic                                 done,
  output logic                                 ignored,
  output logic                                 hit,
  output logic                                 loaded,
  output logic                                 evicted,
  output logic [fpr_pkg::PORT_ADDR_BITS-1:0]   victim_address,
  output logic [fpr_pkg::PORT_FRAME_BITS-1:0]  frame_used
);

  localparam int unsigned STORE_BITS =
    (ADDRESS_BITS < fpr_pkg::PORT_ADDR_BITS) ? ADDRESS_BITS : fpr_pkg::PORT_ADDR_BITS;
  localparam int unsigned IDX_BITS = $clog2(FRAME_COUNT);
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(FRAME_COUNT - 1);
  localparam logic [IDX_BITS-1:0] ONE_IDX  = IDX_BITS'(1);

  logic [STORE_BITS-1:0]  addr;
  logic [STORE_BITS-1:0]  frames [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] valid;
  logic [FRAME_COUNT-1:0] match;
  logic [IDX_BITS-1:0]    head;
  logic [IDX_BITS-1:0]    tail;
  logic                   full;

  logic                   addr_zero;
  logic                   hit_any;
  logic [IDX_BITS-1:0]    hit_idx;
  logic [IDX_BITS-1:0]    head_step;
  logic [IDX_BITS-1:0]    tail_step;

  always_comb begin
    addr_zero = (addr == '0);
    hit_any   = |match;
    hit_idx   = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_BITS'(i);
      end
    end
    head_step = (head == LAST_IDX) ? '0 : head + ONE_IDX;
    tail_step = (tail == LAST_IDX) ? '0 : tail + ONE_IDX;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr <= page_address[STORE_BITS-1:0];
    end
    if (cmd.compare) begin
      for (int i = 0; i < FRAME_COUNT; i++) begin
        match[i] <= valid[i] && (frames[i] == addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      head  <= '0;
      tail  <= '0;
      full  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= cmd.update;
      if (cmd.update && !addr_zero && !hit_any) begin
        if (!full) begin
          valid[tail] <= 1'b1;
          tail        <= tail_step;
          full        <= (tail_step == head);
        end else begin
          head <= head_step;
          tail <= head_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && !addr_zero && !hit_any) begin
      if (!full) begin
        frames[tail] <= addr;
      end else begin
        frames[head] <= addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      ignored        <= 1'b0;
      hit            <= 1'b0;
      loaded         <= 1'b0;
      evicted        <= 1'b0;
      victim_address <= '0;
      frame_used     <= '0;
      priority if (addr_zero) begin
        ignored <= 1'b1;
      end else if (hit_any) begin
        hit        <= 1'b1;
        frame_used <= fpr_pkg::PORT_FRAME_BITS'(hit_idx);
      end else if (!full) begin
        loaded     <= 1'b1;
        frame_used <= fpr_pkg::PORT_FRAME_BITS'(tail);
      end else begin
        loaded         <= 1'b1;
        evicted        <= 1'b1;
        victim_address <= fpr_pkg::PORT_ADDR_BITS'(frames[head]);
        frame_used     <= fpr_pkg::PORT_FRAME_BITS'(head);
      end
    end
  end

endmodule

// ===== design/fifo_page_replacement.sv =====
// Top level of the FIFO page replacement block: controller plus datapath.
//
//  channel  | handshake        | beat
//  ---------+------------------+-----------------------------------------------
//  access   | start, busy      | page_address
//  result   | done (strobe)    | ignored, hit, loaded, evicted, victim_address,
//           |                  | frame_used
//
// An access first compares against every frame, then updates the table and
// pointers; busy is high during the compare state only.
// The result beat appears in the cycle after the update, for one cycle.
// Synchronous reset empties the table through per-frame valid bits at once.
// The receiver cannot stall; a result is dropped if not taken when done is high.
module fifo_page_replacement #(
  parameter int unsigned FRAME_COUNT  = 8,
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [fpr_pkg::PORT_ADDR_BITS-1:0]  page_address,
  output logic                                done,
  output logic                                ignored,
  output logic                                hit,
  output logic                                loaded,
  output logic                                evicted,
  output logic [fpr_pkg::PORT_ADDR_BITS-1:0]  victim_address,
  output logic [fpr_pkg::PORT_FRAME_BITS-1:0] frame_used
);

  fpr_pkg::cmd_t cmd;

  fpr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  fpr_datapath #(
    .FRAME_COUNT  (FRAME_COUNT),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .page_address   (page_address),
    .done           (done),
    .ignored        (ignored),
    .hit            (hit),
    .loaded         (loaded),
    .evicted        (evicted),
    .victim_address (victim_address),
    .frame_used     (frame_used)
  );

endmodule
